// ----- hw/rtl/qvr_pkg.sv -----
// Shared types, constants and width helpers for the quaternion vector rotator.
// Used by the matrix, lane, top-level, checker and testbench files; it depends on nothing else.
package qvr_pkg;

    localparam int QUAT_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int PIPE_DEPTH    = 4;

    localparam logic signed [QUAT_BITS-1:0] QUAT_W_RESET = 16'sd16384;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_QUAT_O2W = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] w;
        logic signed [QUAT_BITS-1:0] x;
        logic signed [QUAT_BITS-1:0] y;
        logic signed [QUAT_BITS-1:0] z;
    } quat_t;

    // Load enables of the two register stages a submodule owns.
    typedef struct packed {
        logic load_a;
        logic load_b;
    } adv_t;

    // Width of an exact matrix entry with 2*frac fractional bits.
    function automatic int exact_bits(input int frac);
        int wide;
        wide = (2 * frac > 2 * QUAT_BITS) ? 2 * frac : 2 * QUAT_BITS;
        return wide + 2;
    endfunction

    // Width of a matrix entry after rounding to frac fractional bits.
    function automatic int ent_bits(input int frac);
        return exact_bits(frac) + 1 - frac;
    endfunction

endpackage

// ----- hw/rtl/qvr_in_if.sv -----
// Input channel of the quaternion vector rotator: handshake and vector payload.
// Stands alone; no package needed.
interface qvr_in_if #(
    parameter int VEC_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] vec_x;
    logic signed [VEC_BITS-1:0] vec_y;
    logic signed [VEC_BITS-1:0] vec_z;
    logic                       to_object;

    modport source (output valid, vec_x, vec_y, vec_z, to_object, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, to_object, output ready);
endinterface

// ----- hw/rtl/qvr_out_if.sv -----
// Output channel of the quaternion vector rotator: handshake and rotated vector.
// Stands alone; no package needed.
interface qvr_out_if #(
    parameter int VEC_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [VEC_BITS-1:0] out_x;
    logic signed [VEC_BITS-1:0] out_y;
    logic signed [VEC_BITS-1:0] out_z;
    logic                       clipped;

    modport source (output valid, out_x, out_y, out_z, clipped, input ready);
    modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// ----- hw/rtl/qvr_matrix.sv -----
// Two pipeline stages that turn the quaternion into rounded rotation matrix entries.
// Depends on qvr_pkg.
module qvr_matrix #(
    parameter int FRAC_BITS = 14,
    localparam int ENT_W = qvr_pkg::ent_bits(FRAC_BITS)
) (
    input  logic                    clk,
    input  qvr_pkg::adv_t           adv,
    input  qvr_pkg::quat_t          quat,
    output logic signed [ENT_W-1:0] ent [3][3]
);
    import qvr_pkg::*;

    localparam int PROD_W = 2 * QUAT_BITS;
    localparam int EX_W   = exact_bits(FRAC_BITS);
    localparam int RND_W  = EX_W + 1;

    localparam logic signed [EX_W-1:0] ONE =
        {{(EX_W-2*FRAC_BITS-1){1'b0}}, 1'b1, {(2*FRAC_BITS){1'b0}}};
    localparam logic signed [RND_W-1:0] HALF =
        {{(RND_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // First stage: the nine distinct quaternion products.
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [PROD_W-1:0] wx_reg, wy_reg, wz_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load_a)
        begin
            xx_reg <= quat.x * quat.x;
            yy_reg <= quat.y * quat.y;
            zz_reg <= quat.z * quat.z;
            xy_reg <= quat.x * quat.y;
            xz_reg <= quat.x * quat.z;
            yz_reg <= quat.y * quat.z;
            wx_reg <= quat.w * quat.x;
            wy_reg <= quat.w * quat.y;
            wz_reg <= quat.w * quat.z;
        end
    end

    // Second stage: exact entries in inertial-to-object form, then rounding.
    logic signed [EX_W-1:0]  ex [3][3];
    logic signed [RND_W-1:0] rnd [3][3];

    always_comb
    begin
        ex[0][0] = ONE - ((EX_W'(yy_reg) + EX_W'(zz_reg)) <<< 1);
        ex[0][1] = (EX_W'(xy_reg) + EX_W'(wz_reg)) <<< 1;
        ex[0][2] = (EX_W'(xz_reg) - EX_W'(wy_reg)) <<< 1;
        ex[1][0] = (EX_W'(xy_reg) - EX_W'(wz_reg)) <<< 1;
        ex[1][1] = ONE - ((EX_W'(xx_reg) + EX_W'(zz_reg)) <<< 1);
        ex[1][2] = (EX_W'(yz_reg) + EX_W'(wx_reg)) <<< 1;
        ex[2][0] = (EX_W'(xz_reg) + EX_W'(wy_reg)) <<< 1;
        ex[2][1] = (EX_W'(yz_reg) - EX_W'(wx_reg)) <<< 1;
        ex[2][2] = ONE - ((EX_W'(xx_reg) + EX_W'(yy_reg)) <<< 1);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rnd[i][j] = (RND_W'(ex[i][j]) + HALF) >>> FRAC_BITS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_b)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ent[i][j] <= rnd[i][j][ENT_W-1:0];
                end
            end
        end
    end

endmodule

// ----- hw/rtl/qvr_lane.sv -----
// One output component: three coefficient-by-component products, then sum,
// rounding and saturation. Depends on qvr_pkg.
module qvr_lane #(
    parameter int VEC_BITS  = 16,
    parameter int FRAC_BITS = 14,
    localparam int ENT_W = qvr_pkg::ent_bits(FRAC_BITS)
) (
    input  logic                       clk,
    input  qvr_pkg::adv_t              adv,
    input  logic signed [ENT_W-1:0]    coef [3],
    input  logic signed [VEC_BITS-1:0] vec [3],
    output logic signed [VEC_BITS-1:0] res,
    output logic                       clip
);
    import qvr_pkg::*;

    localparam int P_W = ENT_W + VEC_BITS;
    localparam int R_W = P_W + 3;

    localparam logic signed [R_W-1:0] HALF =
        {{(R_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [R_W-1:0] HI =
        {{(R_W-VEC_BITS+1){1'b0}}, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [R_W-1:0] LO =
        {{(R_W-VEC_BITS+1){1'b1}}, {(VEC_BITS-1){1'b0}}};

    logic signed [P_W-1:0] prod_reg [3];
    logic signed [R_W-1:0] acc;
    logic signed [R_W-1:0] rnd;
    logic signed [VEC_BITS-1:0] res_next;
    logic                       clip_next;

    always_ff @(posedge clk)
    begin
        if (adv.load_a)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= P_W'(coef[j]) * P_W'(vec[j]);
            end
        end
    end

    always_comb
    begin
        acc = R_W'(prod_reg[0]) + R_W'(prod_reg[1]) + R_W'(prod_reg[2]) + HALF;
        rnd = acc >>> FRAC_BITS;
        if (rnd > HI)
        begin
            res_next  = HI[VEC_BITS-1:0];
            clip_next = 1'b1;
        end
        else if (rnd < LO)
        begin
            res_next  = LO[VEC_BITS-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            res_next  = rnd[VEC_BITS-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_b)
        begin
            res  <= res_next;
            clip <= clip_next;
        end
    end

endmodule

// ----- hw/rtl/quaternion_vector_rotator.sv -----
// Top level of the quaternion vector rotator: configuration registers, valid
// pipeline and the matrix and lane datapath. Depends on qvr_pkg, the two
// channel interfaces, qvr_matrix and qvr_lane.

// The block rotates one signed vector per clock cycle while the output side is
// not stalled, by the rotation held in the quaternion registers. Every transfer
// on the input channel gives exactly one transfer on the output channel, in
// order. The four register stages are: the quaternion
// products, the rounded matrix entries, the nine coefficient-by-component
// products, and the sum with rounding and saturation that feeds the output
// register. The matrix is rebuilt for every vector from the registers as they
// stand, so a register write takes effect for the very next vector; registers
// must only be written while no vector is in flight. A stall on the output side
// holds each occupied stage with no empty stage after it; empty stages fill,
// so the input keeps taking transfers until all four stages are occupied.
module quaternion_vector_rotator #(
    parameter int VEC_BITS  = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [qvr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [qvr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    qvr_in_if.sink                              vec_in,
    qvr_out_if.source                           vec_out
);
    import qvr_pkg::*;

    localparam int ENT_W = ent_bits(FRAC_BITS);

    // Configuration registers. Writes to unused indices are dropped.
    quat_t quat_reg;
    logic  o2w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w <= QUAT_W_RESET;
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            o2w_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUAT_W:   quat_reg.w <= cfg_data[QUAT_BITS-1:0];
                REG_QUAT_X:   quat_reg.x <= cfg_data[QUAT_BITS-1:0];
                REG_QUAT_Y:   quat_reg.y <= cfg_data[QUAT_BITS-1:0];
                REG_QUAT_Z:   quat_reg.z <= cfg_data[QUAT_BITS-1:0];
                REG_QUAT_O2W: o2w_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Valid bits of the four stages. A stage loads when it is empty or when
    // the stage after it is loading too, so bubbles are squeezed out.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    always_comb
    begin
        rdy4 = !v4_reg || vec_out.ready;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        v1_next = rdy1 ? vec_in.valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign vec_in.ready = rdy1;

    // The vector rides alongside the matrix build for the first two stages.
    // The two transpose choices cancel, so only their exclusive OR is kept.
    logic signed [VEC_BITS-1:0] vec_s1_reg [3];
    logic signed [VEC_BITS-1:0] vec_s2_reg [3];
    logic                       to_obj_s1_reg;
    logic                       swap_s2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            vec_s1_reg[0] <= vec_in.vec_x;
            vec_s1_reg[1] <= vec_in.vec_y;
            vec_s1_reg[2] <= vec_in.vec_z;
            to_obj_s1_reg <= vec_in.to_object;
        end
        if (rdy2)
        begin
            vec_s2_reg  <= vec_s1_reg;
            swap_s2_reg <= o2w_reg ^ to_obj_s1_reg;
        end
    end

    adv_t                    mat_adv;
    logic signed [ENT_W-1:0] ent [3][3];

    assign mat_adv.load_a = rdy1;
    assign mat_adv.load_b = rdy2;

    qvr_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .clk  (clk),
        .adv  (mat_adv),
        .quat (quat_reg),
        .ent  (ent)
    );

    // Each lane takes a row of the matrix, or a column when swapped.
    adv_t                       lane_adv;
    logic signed [ENT_W-1:0]    coef [3][3];
    logic signed [VEC_BITS-1:0] res [3];
    logic [2:0]                 clip;

    assign lane_adv.load_a = rdy3;
    assign lane_adv.load_b = rdy4;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                coef[i][j] = swap_s2_reg ? ent[j][i] : ent[i][j];
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        qvr_lane #(
            .VEC_BITS  (VEC_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .adv  (lane_adv),
            .coef (coef[g]),
            .vec  (vec_s2_reg),
            .res  (res[g]),
            .clip (clip[g])
        );
    end

    assign vec_out.valid   = v4_reg;
    assign vec_out.out_x   = res[0];
    assign vec_out.out_y   = res[1];
    assign vec_out.out_z   = res[2];
    assign vec_out.clipped = |clip;

endmodule

// ----- hw/rtl/qvr_checker.sv -----
// Port-level checks for the quaternion vector rotator, attached by bind.
// Depends on qvr_pkg and the top level's ports.
module qvr_checker #(
    parameter int VEC_BITS = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [VEC_BITS-1:0] out_x,
    input logic signed [VEC_BITS-1:0] out_y,
    input logic signed [VEC_BITS-1:0] out_z,
    input logic                       clipped
);
    import qvr_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);
    localparam logic signed [VEC_BITS-1:0] MAXV = {1'b0, {(VEC_BITS-1){1'b1}}};
    localparam logic signed [VEC_BITS-1:0] MINV = {1'b1, {(VEC_BITS-1){1'b0}}};

    logic             in_xfer, out_xfer;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_xfer && !out_xfer)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result stays on offer unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(clipped))
        else $error("stalled result changed");

    // The input only refuses when all four stages are full and the output stalls.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> cnt_reg == CNT_W'(PIPE_DEPTH) && out_valid && !out_ready)
        else $error("input refused with room in the pipeline");

    // With the output side taking every result, an accepted vector reaches the output without stalling.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result late under free-flowing output");

    // A saturated result sits at one end of the range in some component.
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> out_x == MAXV || out_x == MINV || out_y == MAXV
            || out_y == MINV || out_z == MAXV || out_z == MINV)
        else $error("clipped flag without a saturated component");

endmodule

bind quaternion_vector_rotator qvr_checker #(
    .VEC_BITS (VEC_BITS)
) u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_in.valid),
    .in_ready  (vec_in.ready),
    .out_valid (vec_out.valid),
    .out_ready (vec_out.ready),
    .out_x     (vec_out.out_x),
    .out_y     (vec_out.out_y),
    .out_z     (vec_out.out_z),
    .clipped   (vec_out.clipped)
);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the quaternion vector rotator: directed and random
// vector streams, checked against a fixed-point rotation predictor held in the bench.
// Depends on qvr_pkg, qvr_in_if, qvr_out_if and quaternion_vector_rotator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam int     VEC_W   = 16;
    localparam int     FRAC_W  = 14;
    localparam longint VEC_MAX = (longint'(1) << (VEC_W - 1)) - 1;
    localparam longint VEC_MIN = -VEC_MAX - 1;

    // The same two extremes at the width of a vector component.
    localparam logic signed [VEC_W-1:0] VEC_HI = VEC_W'(VEC_MAX);
    localparam logic signed [VEC_W-1:0] VEC_LO = VEC_W'(VEC_MIN);

    // Register indexes above the last defined register are spare; writes there
    // must leave the rotation untouched.
    localparam logic [CFG_IDX_BITS-1:0] FIRST_SPARE_IDX = REG_QUAT_O2W + 3'd1;

    // Random phases: how many, and how many vector transfers each one carries.
    localparam int RAND_PHASES    = 8;
    localparam int VECS_PER_PHASE = 130;

    // The families of quaternion that a random phase may load.
    typedef enum int {
        QUAT_IN_RANGE,
        QUAT_FULL_WORD,
        QUAT_EXTREME,
        QUAT_NEAR_IDENTITY
    } quat_style_t;

    // One rotated vector as it leaves the block.
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    clipped;
    } rotated_vec_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    qvr_in_if  #(.VEC_BITS(VEC_W)) in_ch ();
    qvr_out_if #(.VEC_BITS(VEC_W)) out_ch ();

    // The bench's own copy of the rotation registers, updated on every write.
    quat_t held_quat;
    logic  held_o2w;

    // Rotated vectors still owed by the block, oldest first.
    rotated_vec_t rotated_expected[$];

    int mismatch_count = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // Idle percentages per random phase: none, sender only, receiver only, both.
    int src_idle_tab[4]   = '{0, 63, 0, 36};
    int sink_stall_tab[4] = '{0, 0, 63, 36};

    quaternion_vector_rotator #(
        .VEC_BITS  (VEC_W),
        .FRAC_BITS (FRAC_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vec_in    (in_ch),
        .vec_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A generous ceiling on the whole run; reaching it means the block hung or
    // some expected transfer never came out.
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half towards plus infinity, dropping FRAC_W fractional bits. The
    // shift is arithmetic, so negative values are floored as required.
    function automatic longint round_frac(input longint val);
        return (val + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    // Builds the rotation matrix from the quaternion exactly, rounds each entry
    // to FRAC_W fractional bits, multiplies the vector by it (or by its
    // transpose), rounds the sums to integers and saturates them.
    function automatic rotated_vec_t rotate_by_quat(input quat_t q, input logic o2w,
            input logic signed [VEC_W-1:0] vx, input logic signed [VEC_W-1:0] vy,
            input logic signed [VEC_W-1:0] vz, input logic to_obj);
        longint       w, x, y, z, one, acc, r;
        longint       ent [3][3];
        longint       mat [3][3];
        longint       v [3];
        logic [VEC_W-1:0] res [3];
        logic         clip;
        rotated_vec_t rv;
        w    = longint'($signed(q.w));
        x    = longint'($signed(q.x));
        y    = longint'($signed(q.y));
        z    = longint'($signed(q.z));
        one  = longint'(1) << (2 * FRAC_W);
        clip = 1'b0;

        // Inertial-to-object form; the other convention is its transpose.
        ent[0][0] = one - 2 * (y * y + z * z);
        ent[0][1] = 2 * (x * y + w * z);
        ent[0][2] = 2 * (x * z - w * y);
        ent[1][0] = 2 * (x * y - w * z);
        ent[1][1] = one - 2 * (x * x + z * z);
        ent[1][2] = 2 * (y * z + w * x);
        ent[2][0] = 2 * (x * z + w * y);
        ent[2][1] = 2 * (y * z - w * x);
        ent[2][2] = one - 2 * (x * x + y * y);

        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                mat[i][j] = round_frac(o2w ? ent[j][i] : ent[i][j]);

        v[0] = longint'(vx);
        v[1] = longint'(vy);
        v[2] = longint'(vz);
        for (int i = 0; i < 3; i++)
        begin
            acc = '0;
            for (int j = 0; j < 3; j++)
                acc += (to_obj ? mat[j][i] : mat[i][j]) * v[j];
            r = round_frac(acc);
            if (r > VEC_MAX)
            begin
                r    = VEC_MAX;
                clip = 1'b1;
            end
            if (r < VEC_MIN)
            begin
                r    = VEC_MIN;
                clip = 1'b1;
            end
            res[i] = r[VEC_W-1:0];
        end
        rv.x       = res[0];
        rv.y       = res[1];
        rv.z       = res[2];
        rv.clipped = clip;
        return rv;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Printing stops after the first hundred so that a badly broken block
    // cannot flood the log; every mismatch is still counted.
    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("[%0t] MISMATCH %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_rotated(input rotated_vec_t got);
        rotated_vec_t want;
        if (rotated_expected.size() == 0)
        begin
            report_mismatch($sformatf("output transfer (%0d %0d %0d) with none outstanding",
                                      got.x, got.y, got.z));
            return;
        end
        want = rotated_expected.pop_front();
        if (got.x !== want.x)
            report_mismatch($sformatf("out_x got %0d want %0d", got.x, want.x));
        if (got.y !== want.y)
            report_mismatch($sformatf("out_y got %0d want %0d", got.y, want.y));
        if (got.z !== want.z)
            report_mismatch($sformatf("out_z got %0d want %0d", got.z, want.z));
        if (got.clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %0b want %0b", got.clipped, want.clipped));
    endtask

    // Every output transfer is checked at the rising edge on which it happens.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            check_rotated(rotated_vec_t'{out_ch.out_x, out_ch.out_y, out_ch.out_z,
                                         out_ch.clipped});
    end

    // The receiver refuses transfers at random, at the rate of the current phase.
    initial begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Offers one vector, after a random gap at the sender's idle rate, and
    // records the rotation it must produce once the transfer has happened.
    // Valid stays high on return so that back-to-back vectors need no change.
    task automatic send_vector(input logic signed [VEC_W-1:0] vx,
            input logic signed [VEC_W-1:0] vy, input logic signed [VEC_W-1:0] vz,
            input logic to_obj);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.vec_x     <= vx;
        in_ch.vec_y     <= vy;
        in_ch.vec_z     <= vz;
        in_ch.to_object <= to_obj;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        rotated_expected.push_back(rotate_by_quat(held_quat, held_o2w, vx, vy, vz, to_obj));
    endtask

    // Stops offering vectors and waits until every owed result has come out and
    // the pipeline has settled, so registers may be written.
    task automatic wait_rotator_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (rotated_expected.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One register write. The bench's copy follows the block's decode, so a
    // write to a spare index changes nothing.
    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
            input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_QUAT_W:   held_quat.w = data;
            REG_QUAT_X:   held_quat.x = data;
            REG_QUAT_Y:   held_quat.y = data;
            REG_QUAT_Z:   held_quat.z = data;
            REG_QUAT_O2W: held_o2w    = data[0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_rotation(input logic [CFG_DATA_BITS-1:0] qw,
            input logic [CFG_DATA_BITS-1:0] qx, input logic [CFG_DATA_BITS-1:0] qy,
            input logic [CFG_DATA_BITS-1:0] qz, input logic [CFG_DATA_BITS-1:0] o2w);
        write_cfg(REG_QUAT_W, qw);
        write_cfg(REG_QUAT_X, qx);
        write_cfg(REG_QUAT_Y, qy);
        write_cfg(REG_QUAT_Z, qz);
        write_cfg(REG_QUAT_O2W, o2w);
    endtask

    // Random vector component: mostly full-range words, with the extremes and
    // small values mixed in.
    function automatic logic signed [VEC_W-1:0] pick_component();
        case ($urandom_range(9))
            0:       return VEC_HI;
            1:       return VEC_LO;
            2, 3:    return VEC_W'($urandom_range(400) - 200);
            default: return VEC_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_quat_part(input quat_style_t style);
        case (style)
            QUAT_IN_RANGE:  return CFG_DATA_BITS'($urandom_range(32768) - 16384);
            QUAT_FULL_WORD: return CFG_DATA_BITS'($urandom);
            QUAT_EXTREME:
                case ($urandom_range(4))
                    0:       return 16'h8000;
                    1:       return -16'sd16384;
                    2:       return 16'h0000;
                    3:       return 16'sd16384;
                    default: return 16'h7fff;
                endcase
            default:        return CFG_DATA_BITS'($urandom_range(2000) - 1000);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the quaternion is the identity, so vectors must
    // pass unchanged, extremes included, in either direction.
    task automatic test_reset_identity();
        send_vector(VEC_HI, VEC_LO, 16'sd0, 1'b0);
        send_vector(VEC_LO, VEC_HI, -16'sd1, 1'b1);
        send_vector(16'sd1, -16'sd1, 16'sd12345, 1'b0);
        wait_rotator_idle();
    endtask

    // A quarter turn about z, in both matrix conventions and both directions.
    task automatic test_quarter_turn();
        load_rotation(16'sd11585, 16'h0000, 16'h0000, 16'sd11585, 16'h0000);
        send_vector(VEC_HI, 16'sd0, 16'sd0, 1'b0);
        send_vector(16'sd0, VEC_LO, 16'sd0, 1'b1);
        send_vector(16'sd100, 16'sd200, -16'sd300, 1'b0);
        wait_rotator_idle();
        write_cfg(REG_QUAT_O2W, 16'h0001);
        send_vector(VEC_HI, 16'sd0, 16'sd0, 1'b0);
        send_vector(16'sd0, VEC_LO, 16'sd0, 1'b1);
        send_vector(16'sd100, 16'sd200, -16'sd300, 1'b1);
        wait_rotator_idle();
    endtask

    // Non-unit and out-of-range quaternions are used as they stand, which
    // scales the vector and drives the outputs into saturation.
    task automatic test_non_unit_quat();
        load_rotation(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'h0000);
        send_vector(VEC_HI, VEC_HI, VEC_HI, 1'b0);
        send_vector(VEC_LO, 16'sd1, -16'sd1, 1'b1);
        wait_rotator_idle();
        load_rotation(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 16'hfffe);
        send_vector(VEC_LO, VEC_LO, VEC_LO, 1'b0);
        send_vector(16'sd20000, -16'sd20000, 16'sd5, 1'b1);
        wait_rotator_idle();
        load_rotation(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        send_vector(VEC_HI, VEC_HI, VEC_HI, 1'b0);
        send_vector(VEC_LO, VEC_LO, VEC_LO, 1'b1);
        send_vector(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_vector(16'sd1, 16'sd1, 16'sd1, 1'b1);
        wait_rotator_idle();
    endtask

    // Writes to the spare indexes must leave the loaded rotation as it was.
    task automatic test_spare_index();
        load_rotation(16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 16'h0000);
        send_vector(16'sd1000, -16'sd2000, 16'sd3000, 1'b0);
        wait_rotator_idle();
        for (int k = int'(FIRST_SPARE_IDX); k < (1 << CFG_IDX_BITS); k++)
            write_cfg(CFG_IDX_BITS'(k), 16'hffff);
        send_vector(16'sd1000, -16'sd2000, 16'sd3000, 1'b0);
        send_vector(-16'sd1000, 16'sd2000, -16'sd3000, 1'b1);
        wait_rotator_idle();
    endtask

    // Random phases, each with its own rotation and idle pattern. The style
    // and the idle pattern advance at different rates so that each of the four
    // styles meets two different idle patterns over the run.
    task automatic test_random_stream();
        quat_style_t style;
        int          mode;
        logic [CFG_DATA_BITS-1:0] qw;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            style = quat_style_t'(p % 4);
            mode  = (p + p / 4) % 4;
            wait_rotator_idle();
            src_idle_pct   = src_idle_tab[mode];
            sink_stall_pct = sink_stall_tab[mode];
            qw = (style == QUAT_NEAR_IDENTITY)
                     ? CFG_DATA_BITS'(16384 - $urandom_range(600))
                     : pick_quat_part(style);
            load_rotation(qw, pick_quat_part(style), pick_quat_part(style),
                          pick_quat_part(style), CFG_DATA_BITS'($urandom));
            for (int n = 0; n < VECS_PER_PHASE; n++)
                send_vector(pick_component(), pick_component(), pick_component(),
                            1'($urandom_range(1)));
        end
        wait_rotator_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_QUAT_W;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.vec_x     <= '0;
        in_ch.vec_y     <= '0;
        in_ch.vec_z     <= '0;
        in_ch.to_object <= 1'b0;
        held_quat.w      = QUAT_W_RESET;
        held_quat.x      = '0;
        held_quat.y      = '0;
        held_quat.z      = '0;
        held_o2w         = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_identity();
        test_quarter_turn();
        test_non_unit_quat();
        test_spare_index();
        test_random_stream();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
